[hdl/gbra_pkg.sv]
// Shared types and constants of the group-by reduce accumulator.
package gbra_pkg;

    localparam int ACC_W      = 48;
    localparam int VAL_W      = 32;
    localparam int EXT_W      = 11;
    localparam int IDX_W      = 10;
    localparam int ADDR_MAX_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FREE_W     = 3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ONE_Q16 = 48'sd65536;

    // Reducer codes; the unused code behaves as sum.
    localparam logic [2:0] MODE_SUM     = 3'd0;
    localparam logic [2:0] MODE_MEAN    = 3'd1;
    localparam logic [2:0] MODE_PRODUCT = 3'd2;
    localparam logic [2:0] MODE_MAX     = 3'd3;
    localparam logic [2:0] MODE_MIN     = 3'd4;
    localparam logic [2:0] MODE_ANY     = 3'd5;
    localparam logic [2:0] MODE_ALL     = 3'd6;

    localparam logic [1:0] OP_CONTRIB = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UNDEF   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SUB  = 2'd1;
    localparam logic [1:0] ST_BAD_READ = 2'd2;

    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_FILL = 3'd1;
    localparam logic [2:0] CFG_DIMS = 3'd2;
    localparam logic [2:0] CFG_EXT1 = 3'd3;
    localparam logic [2:0] CFG_EXT2 = 3'd4;
    localparam logic [2:0] CFG_EXT3 = 3'd5;

    typedef enum logic [1:0] {K_NOP, K_CONTRIB, K_READ, K_CLEAR} t_kind;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [VAL_W-1:0] fill;
        logic [1:0]              dims;
        logic [EXT_W-1:0]        ext1;
        logic [EXT_W-1:0]        ext2;
        logic [EXT_W-1:0]        ext3;
    } t_cfg;

    typedef struct packed {
        t_kind                   kind;
        logic [1:0]              status;
        logic [ADDR_MAX_W-1:0]   addr;
        logic signed [VAL_W-1:0] value;
    } t_qent;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [ACC_W-1:0] result_value;
        logic                    cell_touched;
    } t_res;

endpackage

[hdl/gbra_if.sv]
// Channel interfaces: input words, result words and configuration writes.
interface gbra_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [10:0]        sub_first;
    logic [10:0]        sub_second;
    logic [10:0]        sub_third;
    logic signed [31:0] value;
    logic [9:0]         cell_index;

    modport source (output valid, op, sub_first, sub_second, sub_third, value, cell_index,
                    input ready);
    modport sink (input valid, op, sub_first, sub_second, sub_third, value, cell_index,
                  output ready);
endinterface

interface gbra_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [47:0] result_value;
    logic               cell_touched;

    modport source (output valid, status, result_value, cell_touched, input ready);
    modport sink (input valid, status, result_value, cell_touched, output ready);
endinterface

interface gbra_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/gbra_fifo.sv]
// Short queue of classified words between front and back.
module gbra_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gbra_pkg::t_qent i_ent,
    input  logic            i_pop,
    output gbra_pkg::t_qent o_ent,
    output logic            o_empty,
    output logic [gbra_pkg::FREE_W-1:0] o_free
);
    import gbra_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_qent             r_mem [FIFO_DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [FREE_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + FREE_W'(i_push) - FREE_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_ent;
    end

    assign o_ent   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_free  = FREE_W'(FIFO_DEPTH) - r_cnt;
endmodule

[hdl/gbra_front.sv]
// Front end: accept input words, check subscripts, form the cell index.
module gbra_front #(
    parameter int CELLS    = 1024,
    parameter int MAX_DIMS = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gbra_in_if.sink         i_in,
    input  gbra_pkg::t_cfg  i_cfg,
    input  logic            i_cfg_wr,
    input  logic            i_init_done,
    input  logic [gbra_pkg::FREE_W-1:0] i_free,
    output logic            o_push,
    output gbra_pkg::t_qent o_ent
);
    import gbra_pkg::*;

    logic [21:0]       r_e12;
    logic [32:0]       r_total;
    logic [1:0]        r_hold;
    logic              r_s1_valid;
    logic [1:0]        r_op;
    logic              r_bad;
    logic [10:0]       r_p1;
    logic [21:0]       r_p2;
    logic [32:0]       r_p3;
    logic signed [31:0] r_value;
    logic [IDX_W-1:0]  r_idx;

    logic       accept;
    logic [1:0] dims;
    logic       bad1, bad2, bad3;
    logic [33:0] lin;
    logic        zero_ext;
    logic        read_bad;

    // Hold off after a configuration write until the stride products settle.
    assign i_in.ready = i_init_done && (r_hold == 2'd0) &&
                        (r_s1_valid ? (i_free >= FREE_W'(2)) : (i_free >= FREE_W'(1)));
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        dims = (i_cfg.dims == 2'd0) ? 2'd1 : i_cfg.dims;
        if (dims > 2'(MAX_DIMS)) dims = 2'(MAX_DIMS);
        bad1 = (i_in.sub_first == '0) || (i_in.sub_first > i_cfg.ext1);
        bad2 = (dims >= 2'd2) && ((i_in.sub_second == '0) || (i_in.sub_second > i_cfg.ext2));
        bad3 = (dims >= 2'd3) && ((i_in.sub_third == '0) || (i_in.sub_third > i_cfg.ext3));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= 2'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) r_hold <= 2'd2;
            else if (r_hold != 2'd0) r_hold <= r_hold - 2'd1;
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e12   <= i_cfg.ext1 * i_cfg.ext2;
        r_total <= r_e12 * i_cfg.ext3;
        if (accept) begin
            r_op    <= i_in.op;
            r_bad   <= bad1 || bad2 || bad3;
            r_p1    <= i_in.sub_first - 11'd1;
            r_p2    <= (dims >= 2'd2) ? (i_in.sub_second - 11'd1) * i_cfg.ext1 : '0;
            r_p3    <= (dims >= 2'd3) ? (i_in.sub_third - 11'd1) * r_e12 : '0;
            r_value <= i_in.value;
            r_idx   <= i_in.cell_index;
        end
    end

    always_comb begin
        lin      = 34'(r_p1) + 34'(r_p2) + 34'(r_p3);
        zero_ext = (i_cfg.ext1 == '0) || (i_cfg.ext2 == '0) || (i_cfg.ext3 == '0);
        read_bad = (34'(r_idx) >= 34'(r_total)) || (17'(r_idx) >= 17'(CELLS));
        o_push       = r_s1_valid;
        o_ent.kind   = K_NOP;
        o_ent.status = ST_OK;
        o_ent.addr   = '0;
        o_ent.value  = r_value;
        unique case (r_op)
            OP_CONTRIB: begin
                if (zero_ext) begin
                    o_ent.kind = K_NOP;
                end else if (r_bad || (lin >= 34'(CELLS))) begin
                    o_ent.status = ST_BAD_SUB;
                end else begin
                    o_ent.kind = K_CONTRIB;
                    o_ent.addr = lin[ADDR_MAX_W-1:0];
                end
            end
            OP_READ: begin
                if (read_bad) begin
                    o_ent.status = ST_BAD_READ;
                end else begin
                    o_ent.kind = K_READ;
                    o_ent.addr = ADDR_MAX_W'(r_idx);
                end
            end
            OP_CLEAR: o_ent.kind = K_CLEAR;
            default:  o_ent.kind = K_NOP;
        endcase
    end
endmodule

[hdl/gbra_back.sv]
// Back end: cell memory read-modify-write, reducers, mean divider, clear sweep.
module gbra_back #(
    parameter int CELLS      = 1024,
    parameter int COUNT_BITS = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbra_pkg::t_cfg  i_cfg,
    input  gbra_pkg::t_qent i_ent,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_init_done,
    gbra_out_if.source      o_out
);
    import gbra_pkg::*;

    localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int W  = 1 + COUNT_BITS + ACC_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_MULLO, S_MULHI, S_PROD, S_DIV
    } t_state;

    logic [W-1:0] mem [CELLS];

    t_state r_state;
    logic [IW-1:0] r_sweep;
    logic r_clr_item;
    logic r_init_done;
    logic r_out_valid;
    t_res r_out;
    t_qent r_ent;
    logic [W-1:0] r_rdata;
    logic [63:0] r_lo;
    logic [47:0] r_hi;
    logic [47:0] r_quo;
    logic [COUNT_BITS-1:0] r_rem, r_div;
    logic [5:0] r_dcnt;
    logic r_dneg;

    logic mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [W-1:0] mem_wdata;

    logic rd_touch;
    logic [COUNT_BITS-1:0] rd_cnt, cnt_next;
    logic signed [ACC_W-1:0] rd_acc, v48, first_val, comb_val, prod_val;
    logic signed [ACC_W:0] sum49;
    logic [ACC_W-1:0] a_mag;
    logic [VAL_W-1:0] b_mag;
    logic [63:0] m;
    logic is_prod;
    logic [COUNT_BITS:0] rem_s;
    logic ge;
    logic [47:0] q_fin;

    always_comb begin
        rd_touch = r_rdata[W-1];
        rd_cnt   = r_rdata[ACC_W +: COUNT_BITS];
        rd_acc   = r_rdata[ACC_W-1:0];
        v48      = {{(ACC_W-VAL_W){r_ent.value[VAL_W-1]}}, r_ent.value};
        cnt_next = !rd_touch ? COUNT_BITS'(1) :
                   ((&rd_cnt) ? rd_cnt : rd_cnt + 1'b1);
        first_val = ((i_cfg.mode == MODE_ANY) || (i_cfg.mode == MODE_ALL)) ?
                    ((r_ent.value != '0) ? ONE_Q16 : '0) : v48;
        sum49 = {rd_acc[ACC_W-1], rd_acc} + {v48[ACC_W-1], v48};
        unique case (i_cfg.mode)
            MODE_MAX: comb_val = (v48 > rd_acc) ? v48 : rd_acc;
            MODE_MIN: comb_val = (v48 < rd_acc) ? v48 : rd_acc;
            MODE_ANY: comb_val = ((rd_acc != '0) || (v48 != '0)) ? ONE_Q16 : '0;
            MODE_ALL: comb_val = ((rd_acc != '0) && (v48 != '0)) ? ONE_Q16 : '0;
            default: begin
                // Saturate on signed overflow of the 48-bit sum.
                if (sum49[ACC_W] != sum49[ACC_W-1])
                    comb_val = sum49[ACC_W] ? ACC_MIN : ACC_MAX;
                else
                    comb_val = sum49[ACC_W-1:0];
            end
        endcase
        is_prod = rd_touch && (i_cfg.mode == MODE_PRODUCT);
        a_mag = rd_acc[ACC_W-1] ? (~rd_acc + 1'b1) : rd_acc;
        b_mag = r_ent.value[VAL_W-1] ? (~r_ent.value + 1'b1) : r_ent.value;
        m = {r_hi[47:0], 16'b0} + {16'b0, r_lo[63:16]};
        if (rd_acc[ACC_W-1] != r_ent.value[VAL_W-1])
            prod_val = (m >= 64'h0000_8000_0000_0000) ? ACC_MIN : (~m[47:0] + 1'b1);
        else
            prod_val = (m > 64'(ACC_MAX)) ? ACC_MAX : m[47:0];
        rem_s = {r_rem, r_quo[47]};
        ge    = rem_s >= {1'b0, r_div};
        q_fin = {r_quo[46:0], ge};
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty && !r_out_valid;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_ent.addr[IW-1:0];
        mem_raddr = i_ent.addr[IW-1:0];
        mem_wdata = {1'b1, cnt_next, comb_val};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = '0;
            end
            S_IDLE: mem_re = o_pop && ((i_ent.kind == K_CONTRIB) || (i_ent.kind == K_READ));
            S_LOAD: begin
                mem_we    = (r_ent.kind == K_CONTRIB) && !is_prod;
                mem_wdata = {1'b1, cnt_next, rd_touch ? comb_val : first_val};
            end
            S_PROD: begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, cnt_next, prod_val};
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_clr_item  <= 1'b0;
            r_init_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_sweep == IW'(CELLS - 1)) begin
                        r_sweep     <= '0;
                        r_init_done <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_clr_item) begin
                            r_out       <= '{status: ST_OK, result_value: '0, cell_touched: 1'b0};
                            r_out_valid <= 1'b1;
                        end
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_ent <= i_ent;
                        unique case (i_ent.kind)
                            K_NOP: begin
                                r_out <= '{status: i_ent.status, result_value: '0,
                                           cell_touched: 1'b0};
                                r_out_valid <= 1'b1;
                            end
                            K_CLEAR: begin
                                r_clr_item <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            default: r_state <= S_LOAD;
                        endcase
                    end
                end
                S_LOAD: begin
                    if (r_ent.kind == K_CONTRIB) begin
                        if (is_prod) begin
                            r_state <= S_MULLO;
                        end else begin
                            r_out <= '{status: ST_OK, result_value: '0, cell_touched: 1'b0};
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else if (!rd_touch) begin
                        r_out <= '{status: ST_OK,
                                   result_value: {{(ACC_W-VAL_W){i_cfg.fill[VAL_W-1]}},
                                                  i_cfg.fill},
                                   cell_touched: 1'b0};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (i_cfg.mode == MODE_MEAN) begin
                        r_quo   <= a_mag;
                        r_rem   <= '0;
                        r_div   <= (rd_cnt == '0) ? COUNT_BITS'(1) : rd_cnt;
                        r_dcnt  <= '0;
                        r_dneg  <= rd_acc[ACC_W-1];
                        r_state <= S_DIV;
                    end else begin
                        r_out <= '{status: ST_OK, result_value: rd_acc, cell_touched: 1'b1};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_MULLO: begin
                    r_lo    <= a_mag[31:0] * b_mag;
                    r_state <= S_MULHI;
                end
                S_MULHI: begin
                    r_hi    <= a_mag[47:32] * b_mag;
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_out <= '{status: ST_OK, result_value: '0, cell_touched: 1'b0};
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_DIV: begin
                    r_rem  <= ge ? COUNT_BITS'(rem_s - {1'b0, r_div}) : COUNT_BITS'(rem_s);
                    r_quo  <= q_fin;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(ACC_W - 1)) begin
                        r_out <= '{status: ST_OK,
                                   result_value: r_dneg ? (~q_fin + 1'b1) : q_fin,
                                   cell_touched: 1'b1};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_init_done        = r_init_done;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.result_value = r_out.result_value;
    assign o_out.cell_touched = r_out.cell_touched;
endmodule

[hdl/group_by_reduce_accumulator.sv]
// Top level of the group-by reduce accumulator: configuration registers and wiring.
//
// Scatter-reduce engine over CELLS cells. A contribute word folds a Q16.16 value into
// the cell named by up to three one-based subscripts (column-major); a read word
// returns the cell's finished Q32.16 value, or the fill value for an untouched cell;
// a clear word marks every cell untouched. The front end checks subscripts and forms
// the cell index from registered partial products, and keeps accepting words into a
// four-deep queue while the back end works. The back end does one read-modify-write
// of the single cell memory per contribute word; a product contribute first forms the
// product in a low and a high multiply step, a mean read divides at one quotient bit
// per cycle, and a clear sweeps every cell. After reset a sweep clears the memory
// before any word is accepted; configuration writes are taken throughout. After each
// configuration write, input is held off while the stride products settle.
module group_by_reduce_accumulator #(
    parameter int CELLS      = 1024,
    parameter int MAX_DIMS   = 3,
    parameter int COUNT_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbra_in_if.sink    i_in,
    gbra_out_if.source o_out,
    gbra_cfg_if.sink   i_cfg
);
    import gbra_pkg::*;

    t_cfg  r_cfg;
    t_qent fe_ent, q_ent;
    logic  fe_push, q_pop, q_empty, init_done;
    logic [FREE_W-1:0] q_free;

    // Always take configuration words; writes beyond the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_SUM, fill: '0, dims: 2'd1,
                       ext1: 11'd1024, ext2: 11'd1, ext3: 11'd1};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MODE: r_cfg.mode <= i_cfg.data[2:0];
                CFG_FILL: r_cfg.fill <= i_cfg.data;
                CFG_DIMS: r_cfg.dims <= i_cfg.data[1:0];
                CFG_EXT1: r_cfg.ext1 <= i_cfg.data[EXT_W-1:0];
                CFG_EXT2: r_cfg.ext2 <= i_cfg.data[EXT_W-1:0];
                CFG_EXT3: r_cfg.ext3 <= i_cfg.data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    gbra_front #(.CELLS(CELLS), .MAX_DIMS(MAX_DIMS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (i_cfg.valid),
        .i_init_done (init_done),
        .i_free      (q_free),
        .o_push      (fe_push),
        .o_ent       (fe_ent)
    );

    gbra_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_ent   (fe_ent),
        .i_pop   (q_pop),
        .o_ent   (q_ent),
        .o_empty (q_empty),
        .o_free  (q_free)
    );

    gbra_back #(.CELLS(CELLS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ent       (q_ent),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_init_done (init_done),
        .o_out       (o_out)
    );
endmodule
